/* rtl/lsm_pkg.sv */
// shared types, constants and helpers for the line substring matcher
`default_nettype none

package lsm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int PAT_CHARS       = 16;
    localparam int LEN_BITS        = 5;
    localparam int FIELD_BITS      = 24;
    localparam int APB_ADDR_BITS   = 5;
    localparam int APB_DATA_BITS   = 64;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [PAT_CHARS-1:0][7:0] chars;
        logic [LEN_BITS-1:0]       act_len;
    } lsm_cfg_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/lsm_cfg.sv */
// apb register bank holding the search pattern and its length
`default_nettype none

module lsm_cfg #(
    parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lsm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [lsm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [lsm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output lsm_pkg::lsm_cfg_t                       cfg
);
    import lsm_pkg::*;

    logic [63:0]         pat_low_reg;
    logic [63:0]         pat_high_reg;
    logic [LEN_BITS-1:0] pat_len_reg;
    logic [1:0]          reg_sel;
    logic                wr_en;
    logic [LEN_BITS-1:0] len_clip;

    localparam logic [LEN_BITS-1:0] LEN_CAP =
        (PATTERN_MAX < PAT_CHARS) ? LEN_BITS'(PATTERN_MAX) : LEN_BITS'(PAT_CHARS);

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PATTERN_LOW:    pat_low_reg  <= pwdata[63:0];
                REG_PATTERN_HIGH:   pat_high_reg <= pwdata[63:0];
                REG_PATTERN_LENGTH: pat_len_reg  <= pwdata[LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            REG_PATTERN_LENGTH: prdata = {{(APB_DATA_BITS-LEN_BITS){1'b0}}, pat_len_reg};
            default:            prdata = '0;
        endcase
    end

    assign len_clip    = (pat_len_reg > LEN_CAP) ? LEN_CAP : pat_len_reg;
    assign cfg.chars   = {pat_high_reg, pat_low_reg};
    assign cfg.act_len = len_clip;

endmodule

`default_nettype wire

/* rtl/lsm_cell.sv */
// one window cell: holds a line byte, passes it on, checks it against its pattern char
`default_nettype none

module lsm_cell #(
    parameter int IDX = 0
) (
    input  wire logic              clk,
    input  wire logic              shift_en,
    input  wire logic [7:0]        byte_in,
    input  wire lsm_pkg::lsm_cfg_t cfg,
    output logic      [7:0]        byte_out,
    output logic                   char_ok
);
    import lsm_pkg::*;

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    generate
        if (IDX < PAT_CHARS)
        begin : g_active
            logic [LEN_BITS-1:0] sel;
            logic                in_use;
            assign sel     = cfg.act_len - LEN_BITS'(IDX + 1);
            assign in_use  = LEN_BITS'(IDX) < cfg.act_len;
            assign char_ok = !in_use || (byte_in == fold_char(cfg.chars[sel[3:0]]));
        end
        else
        begin : g_spare
            assign char_ok = 1'b1;
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/line_substring_matcher_top.sv */
// top level of the line substring matcher: stream ports, line control and cell row
`default_nettype none

// Bytes of a file enter on the slave stream (tdata byte, tlast marks the last
// byte of the file) at one byte per clock; a result for each ended line leaves
// on the master stream in the cycle after the byte that ends it. The row of window
// cells shifts and compares the newest bytes against the pattern in that same
// cycle, so one byte per cycle is sustained; the single output register accepts
// the next byte while a result waits, and only a stalled result with m_tready
// low holds the input. Configuration writes take effect on the next byte.
module line_substring_matcher_top #(
    parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = lsm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lsm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [lsm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [lsm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // data_byte
    input  wire logic                               s_tlast,  // end_of_file
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [47:0]                        m_tdata,  // line_number, match_total
    output logic                                    m_tuser,  // line_matched
    output logic                                    m_tlast   // file_done
);
    import lsm_pkg::*;

    localparam int FW   = $clog2(PATTERN_MAX + 1);
    localparam int CMPW = (FW > LEN_BITS) ? FW : LEN_BITS;
    localparam logic [FW-1:0] FILL_MAX = FW'(PATTERN_MAX);

    lsm_cfg_t cfg;

    lsm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                  accept;
    logic                  shift_en;
    logic [7:0]            folded;
    logic                  is_nul;
    logic                  is_nl;
    logic                  plain;
    logic                  win_hit;

    logic [FW-1:0]         fill_reg, fill_next, fill_inc;
    logic                  hit_reg, hit_next, hit_cur;
    logic [COUNT_BITS-1:0] line_cnt_reg, line_cnt_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next, hit_cnt_end;
    logic                  skip_reg, skip_next;
    logic                  matched;
    logic                  emit;
    logic                  closes;

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_line_reg, out_total_reg;
    logic                  out_match_reg, out_done_reg;

    logic [7:0]            chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] ok_vec;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign folded   = fold_char(s_tdata);
    assign is_nul   = s_tdata == CHAR_NUL;
    assign is_nl    = s_tdata == CHAR_NEWLINE;
    assign plain    = !is_nul && !is_nl;
    assign shift_en = accept && !skip_reg && plain;
    assign chain[0] = folded;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            lsm_cell #(.IDX(gi)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .byte_in  (chain[gi]),
                .cfg      (cfg),
                .byte_out (chain[gi+1]),
                .char_ok  (ok_vec[gi])
            );
        end
    endgenerate

    assign fill_inc = (fill_reg < FILL_MAX) ? fill_reg + FW'(1) : fill_reg;
    assign win_hit  = (&ok_vec) && (cfg.act_len != '0)
                   && (CMPW'(fill_inc) >= CMPW'(cfg.act_len));
    assign hit_cur  = plain ? (hit_reg || win_hit) : hit_reg;
    assign matched  = hit_cur || (cfg.act_len == '0);
    assign hit_cnt_end = (matched && (hit_cnt_reg != '1)) ? hit_cnt_reg + COUNT_BITS'(1)
                                                          : hit_cnt_reg;

    always_comb
    begin
        fill_next     = fill_reg;
        hit_next      = hit_reg;
        line_cnt_next = line_cnt_reg;
        hit_cnt_next  = hit_cnt_reg;
        skip_next     = skip_reg;
        emit          = 1'b0;
        closes        = 1'b0;
        if (accept)
        begin
            if (skip_reg)
            begin
                if (s_tlast)
                begin
                    skip_next     = 1'b0;
                    fill_next     = '0;
                    hit_next      = 1'b0;
                    line_cnt_next = COUNT_BITS'(1);
                    hit_cnt_next  = '0;
                end
            end
            else if (plain && !s_tlast)
            begin
                fill_next = fill_inc;
                hit_next  = hit_cur;
            end
            else
            begin
                emit   = 1'b1;
                closes = is_nul || s_tlast;
                if (closes)
                begin
                    fill_next     = '0;
                    hit_next      = 1'b0;
                    line_cnt_next = COUNT_BITS'(1);
                    hit_cnt_next  = '0;
                    skip_next     = is_nul && !s_tlast;
                end
                else
                begin
                    fill_next     = '0;
                    hit_next      = 1'b0;
                    hit_cnt_next  = hit_cnt_end;
                    line_cnt_next = (line_cnt_reg != '1) ? line_cnt_reg + COUNT_BITS'(1)
                                                         : line_cnt_reg;
                end
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            line_cnt_reg  <= COUNT_BITS'(1);
            hit_cnt_reg   <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            line_cnt_reg  <= line_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the transaction that ends a line
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_line_reg  <= FIELD_BITS'(line_cnt_reg);
            out_total_reg <= FIELD_BITS'(hit_cnt_end);
            out_match_reg <= matched;
            out_done_reg  <= closes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_line_reg};
    assign m_tuser  = out_match_reg;
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire
